// ===== sv/hbe_pkg.sv =====
// Shared types and constants of the height-map brush engine.
package hbe_pkg;

   localparam logic [1:0] CMD_STROKE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   localparam logic [2:0] CSR_ROW_LENGTH    = 3'd0;
   localparam logic [2:0] CSR_ROW_COUNT     = 3'd1;
   localparam logic [2:0] CSR_BRUSH_RADIUS  = 3'd2;
   localparam logic [2:0] CSR_INTENSITY     = 3'd3;
   localparam logic [2:0] CSR_RAISE_ENABLE  = 3'd4;
   localparam logic [2:0] CSR_SMOOTH_ENABLE = 3'd5;

   localparam logic [8:0]         ROW_LENGTH_RST   = 9'd64;
   localparam logic [8:0]         ROW_COUNT_RST    = 9'd64;
   localparam logic [6:0]         BRUSH_RADIUS_RST = 7'd4;
   localparam logic signed [15:0] INTENSITY_RST    = 16'sd4096;

   localparam logic signed [23:0] HEIGHT_ONE = 24'sd4096;
   localparam logic signed [23:0] HEIGHT_MAX = 24'sd8388607;
   localparam logic signed [23:0] HEIGHT_MIN = 24'sh800000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] vertex_index;
   } req_type;

   typedef struct packed {
      logic signed [23:0] height_value;
      logic               out_of_range;
   } rsp_type;

endpackage

// ===== sv/hbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hbe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/heightmap_brush_engine.sv =====
// Height-map brush engine: height store, sequencer and shared arithmetic unit.
// Stroke: setup, then (2r)^2 scan steps per pass, then the response;
// a vertex inside the brush takes a 19-step square root and a 28-step divide in raise
// and nine neighbor reads and a 28-step divide in smooth; other vertices are skipped.
// One request at a time. After reset a clearing pass runs.
module heightmap_brush_engine #(
   parameter int STORE_DEPTH = 4096,
   parameter int MAX_RADIUS  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hbe_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hbe_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int AW = $clog2(STORE_DEPTH);

   typedef enum logic [25:0] {
      S_CLEAR  = 26'd1 << 0,
      S_IDLE   = 26'd1 << 1,
      S_NMUL   = 26'd1 << 2,
      S_NSET   = 26'd1 << 3,
      S_PRE1   = 26'd1 << 4,
      S_PRE2   = 26'd1 << 5,
      S_CDIV   = 26'd1 << 6,
      S_BACK   = 26'd1 << 7,
      S_PSTART = 26'd1 << 8,
      S_VCHK   = 26'd1 << 9,
      S_SQ2    = 26'd1 << 10,
      S_SQ3    = 26'd1 << 11,
      S_SQRT   = 26'd1 << 12,
      S_RDIV   = 26'd1 << 13,
      S_RMUL   = 26'd1 << 14,
      S_RWR    = 26'd1 << 15,
      S_NRD    = 26'd1 << 16,
      S_NACC   = 26'd1 << 17,
      S_SLOAD  = 26'd1 << 18,
      S_ADIV   = 26'd1 << 19,
      S_SMUL   = 26'd1 << 20,
      S_SWR    = 26'd1 << 21,
      S_ADV    = 26'd1 << 22,
      S_FETCH  = 26'd1 << 23,
      S_FWAIT  = 26'd1 << 24,
      S_RESP   = 26'd1 << 25
   } state_type;

   state_type state_ff, state_in;

   logic [8:0]         row_length_ff, row_count_ff;
   logic [6:0]         brush_radius_ff;
   logic signed [15:0] intensity_ff;
   logic               raise_en_ff, smooth_en_ff;

   logic [1:0]         cmd_ff, cmd_in;
   logic [11:0]        c_ff, c_in;
   logic [16:0]        n_ff, n_in;
   logic               range_ff, range_in;
   logic               clr_ret_ff, clr_ret_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [14:0]        rl_ff, rl_in;
   logic [13:0]        rr_ff, rr_in;
   logic [11:0]        cr_ff, cr_in;
   logic [8:0]         cc_ff, cc_in;
   logic signed [13:0] brow_ff, brow_in, srow_ff, srow_in, vrow_ff, vrow_in;
   logic [8:0]         bcol_ff, bcol_in, scol_ff, scol_in;
   logic signed [17:0] bv_ff, bv_in, v_ff, v_in;
   logic signed [8:0]  i_ff, i_in, j_ff, j_in;
   logic [6:0]         iter_ff, iter_in;
   logic [3:0]         k_ff, k_in;
   logic               pass_ff, pass_in;
   logic [16:0]        dsq_ff, dsq_in;
   logic [12:0]        ratio_ff, ratio_in;
   logic signed [23:0] h_ff, h_in, avg_ff, avg_in;
   logic signed [27:0] sum_ff, sum_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               hit_ff, hit_in;
   logic [8:0]         dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic [27:0]        dv_quo_ff, dv_quo_in;
   logic [37:0]        sq_x_ff, sq_x_in;
   logic [21:0]        sq_rem_ff, sq_rem_in;
   logic [18:0]        sq_root_ff, sq_root_in;
   logic signed [40:0] prod_ff;
   hbe_pkg::rsp_type   rsp_ff, rsp_in;

   logic [8:0]         len1, cnt1;
   logic [6:0]         rad;
   logic signed [8:0]  rad_s;
   logic signed [24:0] mul_a;
   logic signed [15:0] mul_b;
   logic [9:0]         dv_sh;
   logic               dv_ge;
   logic [8:0]         dv_rem_n;
   logic [27:0]        dv_quo_n;
   logic [21:0]        sq_sh, sq_trial, sq_rem_n;
   logic               sq_ge;
   logic [18:0]        sq_root_n;
   logic signed [13:0] dr;
   logic signed [9:0]  dc;
   logic [17:0]        dist_sq;
   logic signed [17:0] bv0, nbr;
   logic signed [1:0]  ni, nj;
   logic signed [17:0] nrow;
   logic signed [17:0] n_s;
   logic signed [40:0] rnd_full;
   logic signed [29:0] hsum;
   logic signed [23:0] hsat;
   logic signed [27:0] mag;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [23:0]        mem_wdata, mem_rdata;

   assign len1  = (row_length_ff == 9'd0) ? 9'd1 : row_length_ff;
   assign cnt1  = (row_count_ff == 9'd0) ? 9'd1 : row_count_ff;
   assign rad   = (int'(brush_radius_ff) > MAX_RADIUS) ? 7'(MAX_RADIUS) : brush_radius_ff;
   assign rad_s = $signed({2'b00, rad});
   assign n_s   = $signed({1'b0, n_ff});

   assign dv_sh    = {dv_rem_ff, dv_quo_ff[27]};
   assign dv_ge    = dv_sh >= {1'b0, dv_den_ff};
   assign dv_rem_n = dv_ge ? 9'(dv_sh - {1'b0, dv_den_ff}) : 9'(dv_sh);
   assign dv_quo_n = {dv_quo_ff[26:0], dv_ge};

   assign sq_sh     = {sq_rem_ff[19:0], sq_x_ff[37:36]};
   assign sq_trial  = {1'b0, sq_root_ff, 2'b01};
   assign sq_ge     = sq_sh >= sq_trial;
   assign sq_rem_n  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
   assign sq_root_n = {sq_root_ff[17:0], sq_ge};

   assign dr      = vrow_ff - $signed({2'b00, cr_ff});
   assign dc      = $signed({1'b0, bcol_ff}) - $signed({1'b0, cc_ff});
   assign dist_sq = {1'b0, dsq_ff} + 18'(prod_ff[16:0]);
   assign bv0     = $signed({6'd0, c_ff}) - $signed({11'd0, rad});

   always_comb begin
      ni = 2'sd0;
      nj = 2'sd0;
      case (k_ff)
         4'd0: begin ni = -2'sd1; nj = -2'sd1; end
         4'd1: begin ni =  2'sd0; nj = -2'sd1; end
         4'd2: begin ni =  2'sd1; nj = -2'sd1; end
         4'd3: begin ni = -2'sd1; nj =  2'sd0; end
         4'd4: begin ni =  2'sd0; nj =  2'sd0; end
         4'd5: begin ni =  2'sd1; nj =  2'sd0; end
         4'd6: begin ni = -2'sd1; nj =  2'sd1; end
         4'd7: begin ni =  2'sd0; nj =  2'sd1; end
         4'd8: begin ni =  2'sd1; nj =  2'sd1; end
         default: begin ni = 2'sd0; nj = 2'sd0; end
      endcase
   end

   always_comb begin
      nrow = 18'sd0;
      if (nj == -2'sd1) begin
         nrow = -$signed({9'd0, len1});
      end else if (nj == 2'sd1) begin
         nrow = $signed({9'd0, len1});
      end
   end

   assign nbr = v_ff + nrow + 18'(ni);

   assign rnd_full = (prod_ff + 41'sd2048) >>> 12;
   assign hsum     = 30'(h_ff) + 30'(rnd_full);
   assign hsat     = (hsum > 30'(hbe_pkg::HEIGHT_MAX)) ? hbe_pkg::HEIGHT_MAX :
                     (hsum < 30'(hbe_pkg::HEIGHT_MIN)) ? hbe_pkg::HEIGHT_MIN : hsum[23:0];

   assign mag = sum_ff[27] ? (-sum_ff + $signed({24'd0, cnt_ff}) - 28'sd1) : sum_ff;

   always_comb begin
      mul_a = 25'sd0;
      mul_b = 16'sd0;
      case (state_ff)
         S_NMUL: begin
            mul_a = $signed({16'd0, len1});
            mul_b = $signed({7'd0, cnt1});
         end
         S_NSET: begin
            mul_a = $signed({18'd0, rad});
            mul_b = $signed({7'd0, len1});
         end
         S_PRE1: begin
            mul_a = $signed({18'd0, rad});
            mul_b = $signed({9'd0, rad});
         end
         S_VCHK: begin
            mul_a = 25'(dr);
            mul_b = 16'(dr);
         end
         S_SQ2: begin
            mul_a = 25'(dc);
            mul_b = 16'(dc);
         end
         S_RMUL: begin
            mul_a = $signed(25'(14'd8192 - {1'b0, ratio_ff}));
            mul_b = intensity_ff;
         end
         S_SMUL: begin
            mul_a = 25'(avg_ff) - 25'(h_ff);
            mul_b = intensity_ff;
         end
         default: begin
            mul_a = 25'sd0;
            mul_b = 16'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = v_ff[AW-1:0];
      mem_wdata = hsat;
      mem_raddr = AW'(c_ff);
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = hbe_pkg::HEIGHT_ONE;
         end
         S_RWR, S_SWR: begin
            mem_we = 1'b1;
         end
         S_RDIV: begin
            mem_raddr = v_ff[AW-1:0];
         end
         S_NRD: begin
            mem_raddr = nbr[AW-1:0];
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   hbe_ram #(
      .WIDTH(24),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      c_in       = c_ff;
      n_in       = n_ff;
      range_in   = range_ff;
      clr_ret_in = clr_ret_ff;
      clr_in     = clr_ff;
      rl_in      = rl_ff;
      rr_in      = rr_ff;
      cr_in      = cr_ff;
      cc_in      = cc_ff;
      brow_in    = brow_ff;
      bcol_in    = bcol_ff;
      srow_in    = srow_ff;
      scol_in    = scol_ff;
      vrow_in    = vrow_ff;
      bv_in      = bv_ff;
      v_in       = v_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      iter_in    = iter_ff;
      k_in       = k_ff;
      pass_in    = pass_ff;
      dsq_in     = dsq_ff;
      ratio_in   = ratio_ff;
      h_in       = h_ff;
      avg_in     = avg_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      hit_in     = hit_ff;
      dv_rem_in  = dv_rem_ff;
      dv_den_in  = dv_den_ff;
      dv_quo_in  = dv_quo_ff;
      sq_x_in    = sq_x_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      rsp_in     = rsp_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(STORE_DEPTH - 1)) begin
               clr_in   = '0;
               state_in = clr_ret_ff ? S_FETCH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload.cmd;
               c_in     = req_payload.vertex_index;
               state_in = S_NMUL;
            end
         end
         S_NMUL: begin
            state_in = S_NSET;
         end
         S_NSET: begin
            n_in = (prod_ff[16:0] > 17'(STORE_DEPTH)) ? 17'(STORE_DEPTH) : prod_ff[16:0];
            range_in = {5'd0, c_ff} < n_in;
            if (cmd_ff == hbe_pkg::CMD_CLEAR) begin
               clr_ret_in = 1'b1;
               clr_in     = '0;
               state_in   = S_CLEAR;
            end else if (cmd_ff == hbe_pkg::CMD_STROKE && range_in && rad != 7'd0 &&
                         (raise_en_ff || smooth_en_ff)) begin
               state_in = S_PRE1;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_PRE1: begin
            rl_in    = prod_ff[14:0];
            state_in = S_PRE2;
         end
         S_PRE2: begin
            rr_in     = prod_ff[13:0];
            dv_rem_in = '0;
            dv_quo_in = {16'd0, c_ff};
            dv_den_in = len1;
            iter_in   = '0;
            state_in  = S_CDIV;
         end
         S_CDIV: begin
            dv_rem_in = dv_rem_n;
            dv_quo_in = dv_quo_n;
            iter_in   = iter_ff + 7'd1;
            if (iter_ff == 7'd27) begin
               cr_in    = dv_quo_n[11:0];
               cc_in    = dv_rem_n;
               brow_in  = $signed({2'b00, dv_quo_n[11:0]});
               bcol_in  = dv_rem_n;
               iter_in  = rad;
               state_in = S_BACK;
            end
         end
         S_BACK: begin
            if (iter_ff == 7'd0) begin
               srow_in  = brow_ff;
               scol_in  = bcol_ff;
               pass_in  = !raise_en_ff;
               state_in = S_PSTART;
            end else begin
               iter_in = iter_ff - 7'd1;
               if (bcol_ff == 9'd0) begin
                  bcol_in = len1 - 9'd1;
                  brow_in = brow_ff - 14'sd1;
               end else begin
                  bcol_in = bcol_ff - 9'd1;
               end
            end
         end
         S_PSTART: begin
            bv_in    = bv0;
            v_in     = bv0 - $signed({3'd0, rl_ff});
            brow_in  = srow_ff;
            bcol_in  = scol_ff;
            vrow_in  = srow_ff - 14'(rad_s);
            i_in     = -rad_s;
            j_in     = -rad_s;
            state_in = S_VCHK;
         end
         S_VCHK: begin
            state_in = (v_ff < 18'sd0 || v_ff >= n_s) ? S_ADV : S_SQ2;
         end
         S_SQ2: begin
            dsq_in   = prod_ff[16:0];
            state_in = S_SQ3;
         end
         S_SQ3: begin
            if (dist_sq > {4'd0, rr_ff}) begin
               state_in = S_ADV;
            end else if (!pass_ff) begin
               sq_x_in    = {dist_sq[13:0], 24'd0};
               sq_rem_in  = '0;
               sq_root_in = '0;
               iter_in    = '0;
               state_in   = S_SQRT;
            end else begin
               k_in     = '0;
               sum_in   = '0;
               cnt_in   = '0;
               state_in = S_NRD;
            end
         end
         S_SQRT: begin
            sq_x_in    = {sq_x_ff[35:0], 2'b00};
            sq_rem_in  = sq_rem_n;
            sq_root_in = sq_root_n;
            iter_in    = iter_ff + 7'd1;
            if (iter_ff == 7'd18) begin
               dv_rem_in = '0;
               dv_quo_in = {9'd0, sq_root_n};
               dv_den_in = {2'b00, rad};
               iter_in   = '0;
               state_in  = S_RDIV;
            end
         end
         S_RDIV: begin
            dv_rem_in = dv_rem_n;
            dv_quo_in = dv_quo_n;
            iter_in   = iter_ff + 7'd1;
            if (iter_ff == 7'd27) begin
               ratio_in = dv_quo_n[12:0];
               state_in = S_RMUL;
            end
         end
         S_RMUL: begin
            h_in     = $signed(mem_rdata);
            state_in = S_RWR;
         end
         S_RWR: begin
            state_in = S_ADV;
         end
         S_NRD: begin
            hit_in   = !(nbr < 18'sd0 || nbr >= n_s);
            state_in = S_NACC;
         end
         S_NACC: begin
            if (hit_ff) begin
               sum_in = sum_ff + 28'($signed(mem_rdata));
               cnt_in = cnt_ff + 4'd1;
            end
            if (k_ff == 4'd4) begin
               h_in = $signed(mem_rdata);
            end
            k_in     = k_ff + 4'd1;
            state_in = (k_ff == 4'd8) ? S_SLOAD : S_NRD;
         end
         S_SLOAD: begin
            neg_in    = sum_ff[27];
            dv_rem_in = '0;
            dv_quo_in = mag;
            dv_den_in = {5'd0, cnt_ff};
            iter_in   = '0;
            state_in  = S_ADIV;
         end
         S_ADIV: begin
            dv_rem_in = dv_rem_n;
            dv_quo_in = dv_quo_n;
            iter_in   = iter_ff + 7'd1;
            if (iter_ff == 7'd27) begin
               avg_in   = neg_ff ? 24'(-$signed(dv_quo_n)) : 24'($signed(dv_quo_n));
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            state_in = S_SWR;
         end
         S_SWR: begin
            state_in = S_ADV;
         end
         S_ADV: begin
            if (j_ff + 9'sd1 != rad_s) begin
               j_in     = j_ff + 9'sd1;
               v_in     = v_ff + $signed({9'd0, len1});
               vrow_in  = vrow_ff + 14'sd1;
               state_in = S_VCHK;
            end else if (i_ff + 9'sd1 != rad_s) begin
               i_in  = i_ff + 9'sd1;
               j_in  = -rad_s;
               bv_in = bv_ff + 18'sd1;
               v_in  = bv_ff + 18'sd1 - $signed({3'd0, rl_ff});
               if (bcol_ff + 9'd1 == len1) begin
                  bcol_in = 9'd0;
                  brow_in = brow_ff + 14'sd1;
                  vrow_in = brow_ff + 14'sd1 - 14'(rad_s);
               end else begin
                  bcol_in = bcol_ff + 9'd1;
                  vrow_in = brow_ff - 14'(rad_s);
               end
               state_in = S_VCHK;
            end else if (!pass_ff && smooth_en_ff) begin
               pass_in  = 1'b1;
               state_in = S_PSTART;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (range_ff) begin
               state_in = S_FWAIT;
            end else begin
               rsp_in.height_value = '0;
               rsp_in.out_of_range = 1'b1;
               state_in            = S_RESP;
            end
         end
         S_FWAIT: begin
            rsp_in.height_value = $signed(mem_rdata);
            rsp_in.out_of_range = 1'b0;
            state_in            = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_ret_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_ret_ff <= clr_ret_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= hbe_pkg::ROW_LENGTH_RST;
         row_count_ff    <= hbe_pkg::ROW_COUNT_RST;
         brush_radius_ff <= hbe_pkg::BRUSH_RADIUS_RST;
         intensity_ff    <= hbe_pkg::INTENSITY_RST;
         raise_en_ff     <= 1'b1;
         smooth_en_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            hbe_pkg::CSR_ROW_LENGTH:    row_length_ff   <= csr_wdata[8:0];
            hbe_pkg::CSR_ROW_COUNT:     row_count_ff    <= csr_wdata[8:0];
            hbe_pkg::CSR_BRUSH_RADIUS:  brush_radius_ff <= csr_wdata[6:0];
            hbe_pkg::CSR_INTENSITY:     intensity_ff    <= $signed(csr_wdata);
            hbe_pkg::CSR_RAISE_ENABLE:  raise_en_ff     <= csr_wdata[0];
            hbe_pkg::CSR_SMOOTH_ENABLE: smooth_en_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      c_ff       <= c_in;
      n_ff       <= n_in;
      range_ff   <= range_in;
      rl_ff      <= rl_in;
      rr_ff      <= rr_in;
      cr_ff      <= cr_in;
      cc_ff      <= cc_in;
      brow_ff    <= brow_in;
      bcol_ff    <= bcol_in;
      srow_ff    <= srow_in;
      scol_ff    <= scol_in;
      vrow_ff    <= vrow_in;
      bv_ff      <= bv_in;
      v_ff       <= v_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      iter_ff    <= iter_in;
      k_ff       <= k_in;
      pass_ff    <= pass_in;
      dsq_ff     <= dsq_in;
      ratio_ff   <= ratio_in;
      h_ff       <= h_in;
      avg_ff     <= avg_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      hit_ff     <= hit_in;
      dv_rem_ff  <= dv_rem_in;
      dv_den_ff  <= dv_den_in;
      dv_quo_ff  <= dv_quo_in;
      sq_x_ff    <= sq_x_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> state_ff == S_CLEAR)
      else $error("clearing pass does not follow reset");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_RWR || state_ff == S_SWR))
      else $error("store written outside a write step");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.out_of_range) |-> rsp_payload.height_value == 24'sd0)
      else $error("out of range response carries a height");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("ready during clearing pass");
`endif

endmodule
